// ===== src/m3i_pkg.sv =====
// ============================================================================
// m3i_pkg
// Shared widths, constants and types of the 3x3 fixed-point matrix inverter.
// ============================================================================
package m3i_pkg;

    // Element and intermediate widths (Q16.16 elements).
    localparam int ELEM_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int N_ELEM  = 9;
    localparam int PROD_W  = 2 * ELEM_W;          // exact element product
    localparam int COF_W   = PROD_W + 1;          // signed cofactor
    localparam int TERM_W  = COF_W + ELEM_W;      // element times cofactor
    localparam int DET_W   = TERM_W + 1;          // signed determinant
    localparam int MAG_W   = DET_W - 1;           // determinant magnitude
    localparam int NUM_W   = DET_W;               // dividend and divisor width
    localparam int Q_W     = ELEM_W + 1;          // quotient bits kept
    localparam int RND_W   = DET_W - 2 * FRAC_W;  // rounded determinant width
    localparam int THR_W   = 31;

    // Pipeline depths.
    localparam int DET_LAT  = 5;
    localparam int PREP_LAT = 2;
    localparam int DIV_LAT  = Q_W + 1;
    localparam int PIPE_LAT = DET_LAT + PREP_LAT + DIV_LAT;

    localparam logic [THR_W-1:0]  THR_RESET = THR_W'(1);
    localparam logic [ELEM_W-1:0] SAT_POS   = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] SAT_NEG   = {1'b1, {(ELEM_W-1){1'b0}}};

    // Cofactor k is m[a]*m[b] - m[c]*m[d].
    localparam int COF_IDX [N_ELEM][4] = '{
        '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
        '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
        '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
    };

    // Result element k takes the transposed cofactor.
    localparam int ADJ_SRC [N_ELEM] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

    typedef logic [N_ELEM-1:0][ELEM_W-1:0] mat_t;
    typedef logic [N_ELEM-1:0][COF_W-1:0]  cof_arr_t;

    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] den;
    } lane_in_t;

    typedef struct packed {
        logic           neg;
        logic           ovf;
        logic [Q_W-1:0] q;
    } lane_out_t;

    typedef struct packed {
        logic             neg;
        logic             ovf;
        logic [NUM_W-1:0] rem;
        logic [NUM_W-1:0] den;
        logic [Q_W-1:0]   q;
    } div_st_t;

    typedef lane_in_t  [N_ELEM-1:0] lane_in_arr_t;
    typedef lane_out_t [N_ELEM-1:0] lane_out_arr_t;

endpackage

// ===== src/m3i_det.sv =====
// ============================================================================
// m3i_det
// Five-stage pipeline forming the nine exact cofactors and the determinant.
// ============================================================================
module m3i_det
    import m3i_pkg::*;
(
    input  logic             clk,
    input  logic             adv,
    input  mat_t             mat,
    output cof_arr_t         cof,
    output logic [DET_W-1:0] det
);

    // Signed 33 x 33 product in 65 bits, exact while one operand is a sign-extended element.
    function automatic logic signed [COF_W-1:0] smul(
        input logic signed [ELEM_W:0] a,
        input logic signed [ELEM_W:0] b
    );
        smul = a * b;
    endfunction

    logic [2*N_ELEM-1:0][PROD_W-1:0] prod_reg;
    logic [2:0][ELEM_W-1:0]          row1_reg;
    logic [2:0][ELEM_W-1:0]          row2_reg;
    cof_arr_t                        cof2_reg;
    cof_arr_t                        cof3_reg;
    cof_arr_t                        cof4_reg;
    cof_arr_t                        cof5_reg;
    logic [2:0][COF_W-1:0]           pl_reg;
    logic [2:0][COF_W-1:0]           ph_reg;
    logic [2:0][TERM_W-1:0]          term_reg;
    logic [DET_W-1:0]                det_reg;

    // Stage 1: the eighteen element products.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < N_ELEM; k++)
            begin
                prod_reg[2*k]   <= PROD_W'(smul(
                    {mat[COF_IDX[k][0]][ELEM_W-1], mat[COF_IDX[k][0]]},
                    {mat[COF_IDX[k][1]][ELEM_W-1], mat[COF_IDX[k][1]]}));
                prod_reg[2*k+1] <= PROD_W'(smul(
                    {mat[COF_IDX[k][2]][ELEM_W-1], mat[COF_IDX[k][2]]},
                    {mat[COF_IDX[k][3]][ELEM_W-1], mat[COF_IDX[k][3]]}));
            end
            for (int i = 0; i < 3; i++)
            begin
                row1_reg[i] <= mat[i];
            end
        end
    end

    // Stage 2: cofactors as differences of products.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < N_ELEM; k++)
            begin
                cof2_reg[k] <= {prod_reg[2*k][PROD_W-1], prod_reg[2*k]}
                             - {prod_reg[2*k+1][PROD_W-1], prod_reg[2*k+1]};
            end
            row2_reg <= row1_reg;
        end
    end

    // Stage 3: first-row element times cofactor, split into two halves.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pl_reg[i] <= smul({row2_reg[i][ELEM_W-1], row2_reg[i]},
                                  {1'b0, cof2_reg[i][ELEM_W-1:0]});
                ph_reg[i] <= smul({row2_reg[i][ELEM_W-1], row2_reg[i]},
                                  cof2_reg[i][COF_W-1:ELEM_W]);
            end
            cof3_reg <= cof2_reg;
        end
    end

    // Stage 4: join the halves of each term.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                term_reg[i] <= {ph_reg[i], {ELEM_W{1'b0}}}
                             + {{ELEM_W{pl_reg[i][COF_W-1]}}, pl_reg[i]};
            end
            cof4_reg <= cof3_reg;
        end
    end

    // Stage 5: sum of the three terms.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det_reg  <= {term_reg[0][TERM_W-1], term_reg[0]}
                      + {term_reg[1][TERM_W-1], term_reg[1]}
                      + {term_reg[2][TERM_W-1], term_reg[2]};
            cof5_reg <= cof4_reg;
        end
    end

    assign cof = cof5_reg;
    assign det = det_reg;

endmodule

// ===== src/m3i_prep.sv =====
// ============================================================================
// m3i_prep
// Two stages: magnitudes and signs, then the singular test and the dividends.
// ============================================================================
module m3i_prep
    import m3i_pkg::*;
(
    input  logic             clk,
    input  logic             adv,
    input  cof_arr_t         cof,
    input  logic [DET_W-1:0] det,
    input  logic [THR_W-1:0] thr,
    output lane_in_arr_t     lanes,
    output logic             singular
);

    logic [DET_W-1:0]               det_neg;
    cof_arr_t                       cof_neg;
    logic                           dneg_reg;
    logic [MAG_W-1:0]               dmag_reg;
    logic [N_ELEM-1:0]              cneg_reg;
    logic [N_ELEM-1:0][PROD_W-1:0]  cmag_reg;
    logic [DET_W-1:0]               rnd_sum;
    logic [RND_W-1:0]               rnd_q;
    lane_in_arr_t                   lanes_reg;
    logic                           singular_reg;

    // Two's complement negations.
    always_comb
    begin
        det_neg = ~det + 1'b1;
        for (int k = 0; k < N_ELEM; k++)
        begin
            cof_neg[k] = ~cof[k] + 1'b1;
        end
    end

    // Stage 1: magnitudes; the cofactors go to their transposed place.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dneg_reg <= det[DET_W-1];
            dmag_reg <= det[DET_W-1] ? det_neg[MAG_W-1:0] : det[MAG_W-1:0];
            for (int k = 0; k < N_ELEM; k++)
            begin
                cneg_reg[k] <= cof[ADJ_SRC[k]][COF_W-1];
                cmag_reg[k] <= cof[ADJ_SRC[k]][COF_W-1]
                             ? cof_neg[ADJ_SRC[k]][PROD_W-1:0]
                             : cof[ADJ_SRC[k]][PROD_W-1:0];
            end
        end
    end

    // Determinant rounded half up to Q16.16 for the threshold test.
    assign rnd_sum = {1'b0, dmag_reg} + (DET_W'(1) << (2*FRAC_W - 1));
    assign rnd_q   = rnd_sum[DET_W-1:2*FRAC_W];

    // Stage 2: singular decision and the rounded-division operands.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            singular_reg <= (dmag_reg == '0) || (rnd_q < RND_W'(thr));
            for (int k = 0; k < N_ELEM; k++)
            begin
                lanes_reg[k].neg <= (cneg_reg[k] != dneg_reg) && (cmag_reg[k] != '0);
                lanes_reg[k].num <= {1'b0, cmag_reg[k], {(2*FRAC_W+1){1'b0}}}
                                  + {1'b0, dmag_reg};
                lanes_reg[k].den <= {dmag_reg, 1'b0};
            end
        end
    end

    assign lanes    = lanes_reg;
    assign singular = singular_reg;

endmodule

// ===== src/m3i_div_lane.sv =====
// ============================================================================
// m3i_div_lane
// Pipelined restoring divider: an overflow check, then one quotient bit a stage.
// ============================================================================
module m3i_div_lane
    import m3i_pkg::*;
(
    input  logic      clk,
    input  logic      adv,
    input  lane_in_t  din,
    output lane_out_t dout
);

    div_st_t st_reg  [DIV_LAT];
    div_st_t st_next [DIV_LAT];

    // Next value of every stage.
    always_comb
    begin
        logic [NUM_W+Q_W-1:0] sh;
        // Stage 0: a quotient that needs more than Q_W bits saturates.
        st_next[0].neg = din.neg;
        st_next[0].ovf = {{Q_W{1'b0}}, din.num} >= {din.den, {Q_W{1'b0}}};
        st_next[0].rem = din.num;
        st_next[0].den = din.den;
        st_next[0].q   = '0;
        // One stage for each quotient bit, most significant first.
        for (int s = 1; s < DIV_LAT; s++)
        begin
            sh         = {{Q_W{1'b0}}, st_reg[s-1].den} << (Q_W - s);
            st_next[s] = st_reg[s-1];
            if ({{Q_W{1'b0}}, st_reg[s-1].rem} >= sh)
            begin
                st_next[s].rem        = st_reg[s-1].rem - sh[NUM_W-1:0];
                st_next[s].q[Q_W - s] = 1'b1;
            end
        end
    end

    // Stage registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < DIV_LAT; s++)
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign dout.neg = st_reg[DIV_LAT-1].neg;
    assign dout.ovf = st_reg[DIV_LAT-1].ovf;
    assign dout.q   = st_reg[DIV_LAT-1].q;

endmodule

// ===== src/matrix3_inverse.sv =====
// ============================================================================
// matrix3_inverse
// Inverts one signed Q16.16 3x3 matrix per beat through 42 register stages; a
// new beat can enter in every cycle while the output is not stalled. The depth
// is set by the nine divider lanes, each an overflow check and then one quotient
// bit per stage (34 stages), behind five stages of cofactor and determinant
// arithmetic, two stages of operand preparation and the output register. A
// stalled output holds the whole pipeline.
// ============================================================================
module matrix3_inverse
    import m3i_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [THR_W-1:0]         cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [ELEM_W-1:0] m00,
    input  logic signed [ELEM_W-1:0] m01,
    input  logic signed [ELEM_W-1:0] m02,
    input  logic signed [ELEM_W-1:0] m10,
    input  logic signed [ELEM_W-1:0] m11,
    input  logic signed [ELEM_W-1:0] m12,
    input  logic signed [ELEM_W-1:0] m20,
    input  logic signed [ELEM_W-1:0] m21,
    input  logic signed [ELEM_W-1:0] m22,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [ELEM_W-1:0] r00,
    output logic signed [ELEM_W-1:0] r01,
    output logic signed [ELEM_W-1:0] r02,
    output logic signed [ELEM_W-1:0] r10,
    output logic signed [ELEM_W-1:0] r11,
    output logic signed [ELEM_W-1:0] r12,
    output logic signed [ELEM_W-1:0] r20,
    output logic signed [ELEM_W-1:0] r21,
    output logic signed [ELEM_W-1:0] r22,
    output logic                     singular,
    output logic                     saturated
);

    logic [THR_W-1:0]    thr_reg;
    logic                adv;
    mat_t                mat;
    cof_arr_t            cof;
    logic [DET_W-1:0]    det;
    lane_in_arr_t        lanes_in;
    lane_out_arr_t       lanes_out;
    logic                prep_singular;
    logic [PIPE_LAT-1:0] vld_reg;
    mat_t                line_reg [PIPE_LAT];
    logic [DIV_LAT-1:0]  sing_reg;
    mat_t                res_next;
    logic                sat_next;
    mat_t                res_reg;
    logic                out_valid_reg;
    logic                singular_reg;
    logic                saturated_reg;

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    // The pipeline moves unless a finished beat is held at the output.
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    assign mat = {m22, m21, m20, m12, m11, m10, m02, m01, m00};

    m3i_det u_det (
        .clk (clk),
        .adv (adv),
        .mat (mat),
        .cof (cof),
        .det (det)
    );

    m3i_prep u_prep (
        .clk      (clk),
        .adv      (adv),
        .cof      (cof),
        .det      (det),
        .thr      (thr_reg),
        .lanes    (lanes_in),
        .singular (prep_singular)
    );

    for (genvar k = 0; k < N_ELEM; k++)
    begin : g_lane
        m3i_div_lane u_lane (
            .clk  (clk),
            .adv  (adv),
            .din  (lanes_in[k]),
            .dout (lanes_out[k])
        );
    end

    // Valid bits and the singular flag travel beside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], in_valid};
        end
    end

    // The input matrix is kept for the singular case.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            line_reg[0] <= mat;
            for (int i = 1; i < PIPE_LAT; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
            sing_reg <= {sing_reg[DIV_LAT-2:0], prep_singular};
        end
    end

    // Sign, saturation and the singular bypass.
    always_comb
    begin
        sat_next = 1'b0;
        for (int k = 0; k < N_ELEM; k++)
        begin
            if (lanes_out[k].neg)
            begin
                if (lanes_out[k].ovf || (lanes_out[k].q > {1'b0, SAT_NEG}))
                begin
                    res_next[k] = SAT_NEG;
                    sat_next    = 1'b1;
                end
                else
                begin
                    res_next[k] = ~lanes_out[k].q[ELEM_W-1:0] + 1'b1;
                end
            end
            else
            begin
                if (lanes_out[k].ovf || (lanes_out[k].q > {1'b0, SAT_POS}))
                begin
                    res_next[k] = SAT_POS;
                    sat_next    = 1'b1;
                end
                else
                begin
                    res_next[k] = lanes_out[k].q[ELEM_W-1:0];
                end
            end
        end
        if (sing_reg[DIV_LAT-1])
        begin
            res_next = line_reg[PIPE_LAT-1];
            sat_next = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld_reg[PIPE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg       <= res_next;
            singular_reg  <= sing_reg[DIV_LAT-1];
            saturated_reg <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign r00       = res_reg[0];
    assign r01       = res_reg[1];
    assign r02       = res_reg[2];
    assign r10       = res_reg[3];
    assign r11       = res_reg[4];
    assign r12       = res_reg[5];
    assign r20       = res_reg[6];
    assign r21       = res_reg[7];
    assign r22       = res_reg[8];
    assign singular  = singular_reg;
    assign saturated = saturated_reg;

`ifndef SYNTHESIS
    // A singular beat never reports saturation.
    a_sing_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(singular && saturated))
        else $error("singular beat flagged as saturated");

    // The input is never held while the output stage is empty.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with an empty output stage");

    // A saturated beat carries at least one clipped element.
    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            (r00 == SAT_POS || r00 == SAT_NEG || r01 == SAT_POS || r01 == SAT_NEG ||
             r02 == SAT_POS || r02 == SAT_NEG || r10 == SAT_POS || r10 == SAT_NEG ||
             r11 == SAT_POS || r11 == SAT_NEG || r12 == SAT_POS || r12 == SAT_NEG ||
             r20 == SAT_POS || r20 == SAT_NEG || r21 == SAT_POS || r21 == SAT_NEG ||
             r22 == SAT_POS || r22 == SAT_NEG))
        else $error("saturation flagged without a clipped element");
`endif

endmodule

// ===== bench/matrix3_inverse_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// matrix3_inverse_test
// Self-checking bench for the 3x3 Q16.16 matrix inverter. A directed table of
// matrices comes first, followed by random matrices over several threshold
// settings. Every result beat is compared with a typed or an exact-arithmetic expectation.
// ============================================================================
module matrix3_inverse_test;
    import m3i_pkg::*;

    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  PHASE_ITEMS = 240;
    localparam int  LONG_HOLD   = 300;
    localparam int  N_DIRECTED  = 14;

    typedef struct packed {
        mat_t r;
        logic singular;
        logic saturated;
    } inv_res_t;

    typedef struct packed {
        mat_t     m;
        logic     typed;
        inv_res_t e;
    } inv_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [THR_W-1:0]  cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    mat_t              mat_in = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic signed [ELEM_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic              singular;
    logic              saturated;

    inv_res_t          pending_inverse[$];
    logic [THR_W-1:0]  threshold = THR_RESET;
    int                errors = 0;
    int                cycles = 0;
    bit                hold_req = 1'b0;
    inv_row_t          directed[N_DIRECTED];

    matrix3_inverse uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .m00(mat_in[0]), .m01(mat_in[1]), .m02(mat_in[2]),
        .m10(mat_in[3]), .m11(mat_in[4]), .m12(mat_in[5]),
        .m20(mat_in[6]), .m21(mat_in[7]), .m22(mat_in[8]),
        .out_valid(out_valid), .out_stall(out_stall),
        .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
        .r20(r20), .r21(r21), .r22(r22),
        .singular(singular), .saturated(saturated)
    );

    // Clock generation.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Build a matrix from nine row-major elements.
    function automatic mat_t mat(input logic [31:0] a0, a1, a2, a3, a4, a5,
                                 a6, a7, a8);
        mat_t m;
        m[0] = a0; m[1] = a1; m[2] = a2; m[3] = a3; m[4] = a4;
        m[5] = a5; m[6] = a6; m[7] = a7; m[8] = a8;
        return m;
    endfunction

    // Exact inverse: Q48.48 determinant, singular bypass, rounded quotients, saturation.
    function automatic inv_res_t predict_inverse(input mat_t m,
                                                 input logic [THR_W-1:0] thr);
        logic signed [127:0] e[9];
        logic signed [127:0] c[9];
        logic signed [127:0] det;
        logic signed [127:0] cc;
        logic [127:0] mag, rnd, a, num, den, q;
        logic neg;
        inv_res_t o;
        int k, i, j;
        for (k = 0; k < 9; k++)
            e[k] = $signed(m[k]);
        c[0] = e[4] * e[8] - e[5] * e[7];
        c[1] = e[5] * e[6] - e[3] * e[8];
        c[2] = e[3] * e[7] - e[4] * e[6];
        c[3] = e[2] * e[7] - e[1] * e[8];
        c[4] = e[0] * e[8] - e[2] * e[6];
        c[5] = e[1] * e[6] - e[0] * e[7];
        c[6] = e[1] * e[5] - e[2] * e[4];
        c[7] = e[2] * e[3] - e[0] * e[5];
        c[8] = e[0] * e[4] - e[1] * e[3];
        det = e[0] * c[0] + e[1] * c[1] + e[2] * c[2];
        mag = (det < 0) ? -det : det;
        rnd = (mag + 128'h8000_0000) >> 32;
        o = '0;
        if (mag == 0 || rnd < 128'(thr))
        begin
            o.r = m;
            o.singular = 1'b1;
            return o;
        end
        den = mag << 1;
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
            begin
                cc = c[j * 3 + i];
                a = (cc < 0) ? -cc : cc;
                neg = ((cc < 0) != (det < 0)) && (cc != 0);
                num = (a << 33) + mag;
                q = num / den;
                if (!neg)
                begin
                    if (q > 128'h7fff_ffff)
                    begin
                        o.r[i * 3 + j] = SAT_POS;
                        o.saturated = 1'b1;
                    end
                    else
                        o.r[i * 3 + j] = q[31:0];
                end
                else
                begin
                    if (q > 128'h8000_0000)
                    begin
                        o.r[i * 3 + j] = SAT_NEG;
                        o.saturated = 1'b1;
                    end
                    else
                        o.r[i * 3 + j] = -q[31:0];
                end
            end
        return o;
    endfunction

    // Random element of one of several magnitude classes.
    function automatic logic [31:0] rand_elem(input int kind);
        logic [31:0] v;
        case (kind)
            0: v = $urandom_range(0, 524288) - 262144;
            1: v = $urandom;
            2: v = $urandom >> $urandom_range(0, 31);
            default:
            begin
                case ($urandom_range(0, 5))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'h0;
                    3: v = 32'h1;
                    4: v = 32'hffff_ffff;
                    default: v = 32'h0001_0000;
                endcase
            end
        endcase
        if (kind == 2 && $urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    // Random matrix: well-conditioned, wide, near-singular or degenerate.
    function automatic mat_t rand_matrix();
        mat_t m;
        int pick, k;
        pick = $urandom_range(0, 99);
        for (k = 0; k < 9; k++)
            m[k] = rand_elem(pick < 40 ? 0 : pick < 55 ? 1 : pick < 80 ? 0 : 3);
        if (pick >= 55 && pick < 70)
        begin
            // Third row nearly repeats the first.
            for (k = 0; k < 3; k++)
                m[6 + k] = m[k] + $urandom_range(0, 8) - 4;
        end
        else if (pick >= 70 && pick < 80)
        begin
            // Strong diagonal of mixed magnitude, small off-diagonals.
            m[0] = rand_elem(2);
            m[4] = rand_elem(2);
            m[8] = rand_elem(2);
        end
        else if (pick >= 80 && pick < 90)
        begin
            // Exactly singular: repeated row or zero column.
            if ($urandom_range(0, 1))
                for (k = 0; k < 3; k++)
                    m[3 + k] = m[k];
            else
            begin
                k = $urandom_range(0, 2);
                m[k] = '0; m[3 + k] = '0; m[6 + k] = '0;
            end
        end
        return m;
    endfunction

    // Input side: optional gap, then hold the beat until it is taken.
    task automatic send_matrix(input mat_t m, input inv_res_t e);
        int g, n;
        g = $urandom_range(0, 99);
        n = (g < 60) ? 0 : (g < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        mat_in   <= m;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_inverse.push_back(e);
    endtask

    // Wait until every result is back and the pipeline is empty.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_inverse.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 8) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        threshold = v;
    endtask

    // Output side: random stall pattern, plus one long hold on request.
    initial
    begin
        int left, r;
        logic val;
        left = 0;
        val = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                left = LONG_HOLD;
                val = 1'b1;
            end
            if (left == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    val = 1'b0;
                    left = $urandom_range(1, 30);
                end
                else if (r < 90)
                begin
                    val = 1'b1;
                    left = $urandom_range(1, 3);
                end
                else
                begin
                    val = 1'b1;
                    left = $urandom_range(10, 40);
                end
            end
            out_stall <= val;
            left--;
        end
    end

    // Result checker: every accepted beat against the oldest expectation.
    always @(posedge clk)
    begin
        inv_res_t want;
        mat_t got;
        int k;
        if (rst_n && out_valid && !out_stall)
        begin
            got = mat(r00, r01, r02, r10, r11, r12, r20, r21, r22);
            if (pending_inverse.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                errors++;
            end
            else
            begin
                want = pending_inverse.pop_front();
                for (k = 0; k < 9; k++)
                    if (got[k] !== want.r[k])
                    begin
                        $error("r%0d%0d: expected %h, actual %h", k / 3, k % 3,
                               want.r[k], got[k]);
                        errors++;
                    end
                if (singular !== want.singular)
                begin
                    $error("singular: expected %b, actual %b", want.singular, singular);
                    errors++;
                end
                if (saturated !== want.saturated)
                begin
                    $error("saturated: expected %b, actual %b", want.saturated, saturated);
                    errors++;
                end
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        logic [THR_W-1:0] phase_thr[6];
        mat_t one, m;
        int p, k;

        one = mat(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000);
        // Identity, zero, repeated extremes, scaled identity, negated identity.
        directed[0] = '{one, 1'b1, '{one, 1'b0, 1'b0}};
        directed[1] = '{'0, 1'b1, '{'0, 1'b1, 1'b0}};
        m = {9{32'h8000_0000}};
        directed[2] = '{m, 1'b1, '{m, 1'b1, 1'b0}};
        m = {9{32'h7fff_ffff}};
        directed[3] = '{m, 1'b1, '{m, 1'b1, 1'b0}};
        directed[4] = '{mat(32'h20000, 0, 0, 0, 32'h20000, 0, 0, 0, 32'h20000), 1'b1,
                        '{mat(32'h8000, 0, 0, 0, 32'h8000, 0, 0, 0, 32'h8000), 1'b0, 1'b0}};
        m = mat(32'hffff0000, 0, 0, 0, 32'hffff0000, 0, 0, 0, 32'hffff0000);
        directed[5] = '{m, 1'b1, '{m, 1'b0, 1'b0}};
        // Determinant that rounds to zero is singular under the reset threshold.
        m = mat(1, 0, 0, 0, 1, 0, 0, 0, 1);
        directed[6] = '{m, 1'b1, '{m, 1'b1, 1'b0}};
        // Tiny pivot: positive and negative saturation.
        directed[7] = '{mat(1, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000), 1'b0, '0};
        directed[8] = '{mat(32'hffffffff, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000),
                        1'b0, '0};
        directed[9] = '{mat(32'h8000_0000, 0, 0, 0, 32'h7fff_ffff, 0, 0, 0,
                            32'h8000_0000), 1'b0, '0};
        directed[10] = '{mat(0, 32'h10000, 0, 0, 0, 32'h10000, 32'h10000, 0, 0),
                         1'b0, '0};
        directed[11] = '{mat(32'h20000, 32'h10000, 0, 32'h10000, 32'h30000, 32'h10000,
                             0, 32'h10000, 32'h40000), 1'b0, '0};
        directed[12] = '{mat(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678,
                             32'hdead_beef, 32'h7fff_ffff, 32'h0badf00d,
                             32'h8000_0001, 32'h5555_5555, 32'haaaa_aaaa), 1'b0, '0};
        directed[13] = '{mat(32'h180, 0, 0, 0, 32'h180, 0, 0, 0, 32'h180), 1'b0, '0};

        phase_thr[0] = THR_RESET;
        phase_thr[1] = '0;
        phase_thr[2] = 31'h7fff_ffff;
        phase_thr[3] = 31'h0001_0000;
        phase_thr[4] = THR_W'($urandom_range(0, 1 << 20));
        phase_thr[5] = THR_W'($urandom);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the reset threshold.
        for (k = 0; k < N_DIRECTED; k++)
            send_matrix(directed[k].m, directed[k].typed ? directed[k].e
                        : predict_inverse(directed[k].m, threshold));
        drain();

        // Random phases, one threshold setting each.
        for (p = 0; p < 6; p++)
        begin
            if (p > 0)
                write_threshold(phase_thr[p]);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 1 && k == 40)
                    hold_req = 1'b1;
                m = rand_matrix();
                send_matrix(m, predict_inverse(m, threshold));
            end
            drain();
        end

        if (errors == 0 && pending_inverse.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
